// ===== sv/sprite_rle_line_decoder_macros.svh =====
// Assertion macros for the sprite RLE line decoder.
// Included by srld_back, the RTL file that carries concurrent checks; no dependencies.
`ifndef SPRITE_RLE_LINE_DECODER_MACROS_SVH
`define SPRITE_RLE_LINE_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRLD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/srld_pkg.sv =====
// Shared types and constants for the sprite RLE line decoder.
// No dependencies; used by every module of the block.
package srld_pkg;

  localparam int COORD_W     = 12;  // row / column width on the ports
  localparam int CFG_W       = 12;  // widest configuration register
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] REG_FRAME_WIDTH       = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT      = 2'd1;
  localparam logic [1:0] REG_TRANSPARENT_INDEX = 2'd2;

  localparam logic [7:0] CMD_END_SPRITE  = 8'hFC;
  localparam logic [7:0] CMD_END_LINE    = 8'hFF;  // empty line / line terminator
  localparam logic [7:0] CMD_RUN_LINE    = 8'hFD;
  localparam logic [7:0] CODE_MIXED_RUN  = 8'hFE;
  localparam logic [7:0] PIX_TRANSPARENT = 8'hFD;

  typedef enum logic [2:0] {
    PH_LINE,
    PH_RUN_COUNT,
    PH_RUN_PIXEL,
    PH_MIXED,
    PH_MIXED_COUNT,
    PH_MIXED_PIXEL,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RUN   = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_TRUNC = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] start_column;
    logic [7:0]         run_length;
    logic [7:0]         pixel_value;
    logic               is_transparent;
    logic               last_result;
  } out_item_t;

  // One queue entry: the results caused by one byte (a run, a status, or both).
  typedef struct packed {
    logic               has_run;
    logic               has_stat;
    kind_t              stat_kind;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [7:0]         len;
    logic [7:0]         pix;
    logic               tr;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== sv/srld_front.sv =====
// Front end: configuration registers, byte acceptance and line decode.
// Depends on srld_pkg; pushes one entry per result-producing byte into the queue.
module srld_front #(
  parameter int COORD_BITS = srld_pkg::COORD_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [srld_pkg::CFG_W-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  srld_pkg::in_item_t      in_item,
  input  srld_pkg::qstat_t        q_stat,
  output logic                    push,
  output srld_pkg::qent_t         push_data
);
  import srld_pkg::*;

  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

  logic [COORD_W-1:0]    frame_width;
  logic [COORD_W-1:0]    frame_height;
  logic [7:0]            transparent_index;

  phase_t                phase, phase_next;
  logic [COORD_BITS-1:0] row, row_next;
  logic [COORD_BITS-1:0] col, col_next;
  logic [7:0]            pcount, pcount_next;

  logic [COORD_W+COORD_BITS-1:0] fw_wide, fh_wide;
  logic [COORD_BITS-1:0] w, h;
  logic [COORD_BITS-1:0] avail;
  logic [COORD_BITS+7:0] cnt_wide, avail_wide, len_wide;
  logic [COORD_BITS+COORD_W-1:0] row_wide, col_wide;
  logic [7:0]            b, run_count, len;
  logic                  fin, accept, run_req, emit, finished, line_adv, has_stat, tr;
  kind_t                 stat_kind;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_item.stream_byte;
  assign fin      = in_item.final_byte;

  // Registers are masked to the coordinate width.
  assign fw_wide = {{COORD_BITS{1'b0}}, frame_width};
  assign fh_wide = {{COORD_BITS{1'b0}}, frame_height};
  assign w = fw_wide[COORD_BITS-1:0];
  assign h = fh_wide[COORD_BITS-1:0];

  always_comb begin
    phase_next  = phase;
    row_next    = row;
    col_next    = col;
    pcount_next = pcount;
    run_req     = 1'b0;
    run_count   = pcount;
    finished    = 1'b0;
    line_adv    = 1'b0;
    has_stat    = 1'b0;
    stat_kind   = KIND_DONE;

    case (phase)
      PH_LINE: begin
        if (b == CMD_END_SPRITE) begin
          finished = 1'b1;
        end else if (b == CMD_END_LINE) begin
          line_adv = 1'b1;
        end else if (row >= h) begin
          finished = 1'b1;
        end else if (b == CMD_RUN_LINE) begin
          phase_next = PH_RUN_COUNT;
        end else begin
          phase_next = PH_MIXED;
        end
      end
      PH_RUN_COUNT: begin
        if (b == CMD_END_LINE) begin
          line_adv = 1'b1;
        end else begin
          pcount_next = b;
          phase_next  = PH_RUN_PIXEL;
        end
      end
      PH_RUN_PIXEL: begin
        run_req    = 1'b1;
        phase_next = PH_RUN_COUNT;
      end
      PH_MIXED: begin
        if (b == CMD_END_LINE) begin
          line_adv = 1'b1;
        end else if (b == CODE_MIXED_RUN) begin
          phase_next = PH_MIXED_COUNT;
        end else begin
          run_req   = 1'b1;
          run_count = 8'd1;
        end
      end
      PH_MIXED_COUNT: begin
        pcount_next = b;
        phase_next  = PH_MIXED_PIXEL;
      end
      PH_MIXED_PIXEL: begin
        run_req    = 1'b1;
        phase_next = PH_MIXED;
      end
      default: begin
      end
    endcase

    if (line_adv) begin
      row_next   = (row == COORD_MAX) ? row : row + 1'b1;
      col_next   = '0;
      phase_next = PH_LINE;
    end

    // Run clipping at the frame width
    avail      = w - col;
    cnt_wide   = {{COORD_BITS{1'b0}}, run_count};
    avail_wide = {8'b0, avail};
    len        = (cnt_wide < avail_wide) ? run_count : avail_wide[7:0];
    len_wide   = {{COORD_BITS{1'b0}}, len};
    emit       = run_req && (col < w) && (run_count != 8'd0);
    if (emit) begin
      col_next = col + len_wide[COORD_BITS-1:0];
    end

    if (phase == PH_DONE) begin
      if (fin) begin
        phase_next  = PH_LINE;
        row_next    = '0;
        col_next    = '0;
        pcount_next = '0;
      end
    end else if (finished || fin) begin
      has_stat  = 1'b1;
      stat_kind = (finished || phase_next == PH_LINE) ? KIND_DONE : KIND_TRUNC;
      if (fin) begin
        phase_next  = PH_LINE;
        row_next    = '0;
        col_next    = '0;
        pcount_next = '0;
      end else begin
        phase_next = PH_DONE;
      end
    end
  end

  assign tr       = (b == PIX_TRANSPARENT);
  assign row_wide = {{COORD_W{1'b0}}, row};
  assign col_wide = {{COORD_W{1'b0}}, col};

  always_comb begin
    push_data.has_run   = emit;
    push_data.has_stat  = has_stat;
    push_data.stat_kind = stat_kind;
    push_data.row       = row_wide[COORD_W-1:0];
    push_data.col       = col_wide[COORD_W-1:0];
    push_data.len       = len;
    push_data.pix       = tr ? transparent_index : b;
    push_data.tr        = tr;
  end

  assign push = accept && (emit || has_stat);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_LINE;
      row    <= '0;
      col    <= '0;
      pcount <= '0;
    end else if (accept) begin
      phase  <= phase_next;
      row    <= row_next;
      col    <= col_next;
      pcount <= pcount_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= '0;
      frame_height      <= '0;
      transparent_index <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:       frame_width       <= cfg_data[COORD_W-1:0];
        REG_FRAME_HEIGHT:      frame_height      <= cfg_data[COORD_W-1:0];
        REG_TRANSPARENT_INDEX: transparent_index <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/srld_queue.sv =====
// Short queue of decoded entries between the front and back ends.
// Depends on srld_pkg for the entry and status types.
module srld_queue #(
  parameter int DEPTH = srld_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  srld_pkg::qent_t  push_data,
  input  logic             pop,
  output srld_pkg::qent_t  rd_data,
  output srld_pkg::qstat_t q_stat
);
  import srld_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  qent_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign q_stat.full  = (count == FULL_CNT);
  assign q_stat.empty = (count == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/srld_back.sv =====
// Back end: turns queue entries into result items, one per cycle while out_stall is low.
// Depends on srld_pkg and the assertion macro header.
`include "sprite_rle_line_decoder_macros.svh"

module srld_back (
  input  logic                clk,
  input  logic                rst,
  input  srld_pkg::qstat_t    q_stat,
  input  srld_pkg::qent_t     q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output srld_pkg::out_item_t out_item
);
  import srld_pkg::*;

  logic  load;
  logic  pend_stat;   // status item still owed for the entry just shown
  kind_t pend_kind;

  assign load = !out_valid || !out_stall;
  assign pop  = load && !pend_stat && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_stat <= 1'b0;
    end else if (load) begin
      if (pend_stat) begin
        out_valid <= 1'b1;
        pend_stat <= 1'b0;
      end else if (!q_stat.empty) begin
        out_valid <= 1'b1;
        pend_stat <= q_data.has_run && q_data.has_stat;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_stat) begin
        out_item <= '{kind: pend_kind, row: '0, start_column: '0, run_length: '0,
                      pixel_value: '0, is_transparent: 1'b0, last_result: 1'b1};
      end else if (!q_stat.empty) begin
        pend_kind <= q_data.stat_kind;
        if (q_data.has_run) begin
          out_item <= '{kind: KIND_RUN, row: q_data.row, start_column: q_data.col,
                        run_length: q_data.len, pixel_value: q_data.pix,
                        is_transparent: q_data.tr, last_result: !q_data.has_stat};
        end else begin
          out_item <= '{kind: q_data.stat_kind, row: '0, start_column: '0,
                        run_length: '0, pixel_value: '0, is_transparent: 1'b0,
                        last_result: 1'b1};
        end
      end
    end
  end

  `SRLD_ASSERT_IMPLY(a_pend_after_run, clk, rst, pend_stat,
    out_valid && out_item.kind == KIND_RUN && !out_item.last_result,
    "status owed but shown item is not an open run")
  `SRLD_ASSERT_IMPLY(a_pop_legal, clk, rst, pop,
    !q_stat.empty && (!out_valid || !out_stall),
    "queue popped while empty or while output is held")
  `SRLD_ASSERT_NEXT(a_two_result_split, clk, rst,
    pop && q_data.has_run && q_data.has_stat, pend_stat && out_valid,
    "run plus status entry did not leave a status pending")

endmodule

// ===== sv/sprite_rle_line_decoder.sv =====
// Sprite RLE line decoder: accepts one compressed byte per cycle while in_stall
// is low and gives pixel run descriptors and end-of-sprite status items. The
// front end decodes a byte in the cycle it is taken and pushes its results into
// a four-entry queue; the back end delivers one result item per cycle from an
// output register while out_stall is low. A byte that yields a run and a status
// gives two output items, so the sustained input rate is one byte per cycle only
// while the output keeps up, and the queue absorbs bursts of two-result bytes and
// output stalls. in_stall rises only when the queue is full. Configuration writes
// are taken at any cycle and apply to the next byte accepted.
module sprite_rle_line_decoder #(
  parameter int COORD_BITS  = srld_pkg::COORD_W,
  parameter int QUEUE_DEPTH = srld_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [srld_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  srld_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output srld_pkg::out_item_t        out_item
);
  import srld_pkg::*;

  logic   push, pop;
  qent_t  push_data, q_data;
  qstat_t q_stat;

  srld_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  srld_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (q_data),
    .q_stat    (q_stat)
  );

  srld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== dv/sprite_rle_line_decoder_tb.sv =====
// Self-checking testbench for sprite_rle_line_decoder: directed and random sprite streams,
// a scoreboard class that predicts every run and status item, random idling on both sides.
// Depends on srld_pkg and the sprite_rle_line_decoder RTL.
module sprite_rle_line_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srld_pkg::*;

  localparam logic [1:0] REG_NONE     = 2'd3;  // unmapped index, writes are dropped
  localparam int         DRAIN_CYCLES = 12;
  localparam int         PHASE_ITEMS  = 90;
  localparam int         MAX_PRINTS   = 50;

  // Predicts decoder output from accepted bytes and checks delivered items in order.
  class run_scoreboard;
    localparam logic [11:0] ROW_MAX = 12'hFFF;

    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [7:0]  trans_reg;
    phase_t      phase;
    logic [11:0] row;
    logic [11:0] col;
    logic [7:0]  pend;
    out_item_t   expected_q[$];
    out_item_t   step_q[$];

    function new();
      width_reg  = '0;
      height_reg = '0;
      trans_reg  = '0;
      rearm();
    endfunction

    function void rearm();
      phase = PH_LINE;
      row   = '0;
      col   = '0;
      pend  = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH:       width_reg = val;
        REG_FRAME_HEIGHT:      height_reg = val;
        REG_TRANSPARENT_INDEX: trans_reg = val[7:0];
        default: ;
      endcase
    endfunction

    function void new_line();
      if (row != ROW_MAX) row++;
      col   = '0;
      phase = PH_LINE;
    endfunction

    function void status(kind_t k);
      out_item_t r;
      r      = '0;
      r.kind = k;
      step_q.push_back(r);
    endfunction

    // Runs starting at or past the width, or with a zero count, give nothing.
    function void pixel_run(logic [7:0] count, logic [7:0] pixel);
      out_item_t   r;
      logic [11:0] len;
      if (col >= width_reg || count == 8'd0) return;
      len = width_reg - col;
      if ({4'd0, count} < len) len = {4'd0, count};
      r                = '0;
      r.kind           = KIND_RUN;
      r.row            = row;
      r.start_column   = col;
      r.run_length     = len[7:0];
      r.is_transparent = (pixel == PIX_TRANSPARENT);
      r.pixel_value    = r.is_transparent ? trans_reg : pixel;
      step_q.push_back(r);
      col = col + len;
    endfunction

    function void note_input(in_item_t it);
      logic [7:0] b;
      logic       fin;
      logic       done;
      b    = it.stream_byte;
      fin  = it.final_byte;
      done = 1'b0;
      step_q.delete();
      case (phase)
        PH_LINE: begin
          if (b == CMD_END_SPRITE) done = 1'b1;
          else if (b == CMD_END_LINE) new_line();
          else if (row >= height_reg) done = 1'b1;
          else if (b == CMD_RUN_LINE) phase = PH_RUN_COUNT;
          else phase = PH_MIXED;
        end
        PH_RUN_COUNT: begin
          if (b == CMD_END_LINE) begin
            new_line();
          end else begin
            pend  = b;
            phase = PH_RUN_PIXEL;
          end
        end
        PH_RUN_PIXEL: begin
          pixel_run(pend, b);
          phase = PH_RUN_COUNT;
        end
        PH_MIXED: begin
          if (b == CMD_END_LINE) new_line();
          else if (b == CODE_MIXED_RUN) phase = PH_MIXED_COUNT;
          else pixel_run(8'd1, b);
        end
        PH_MIXED_COUNT: begin
          pend  = b;
          phase = PH_MIXED_PIXEL;
        end
        PH_MIXED_PIXEL: begin
          pixel_run(pend, b);
          phase = PH_MIXED;
        end
        default: begin
          // finished early: swallow bytes until the final one re-arms
          if (fin) rearm();
          return;
        end
      endcase
      if (done) begin
        status(KIND_DONE);
        if (fin) rearm();
        else phase = PH_DONE;
      end else if (fin) begin
        status(phase == PH_LINE ? KIND_DONE : KIND_TRUNC);
        rearm();
      end
      if (step_q.size() > 0) step_q[step_q.size()-1].last_result = 1'b1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    function bit check_result(out_item_t got, output string msg);
      out_item_t want;
      if (expected_q.size() == 0) begin
        msg = $sformatf("unexpected item %h", got);
        return 1'b0;
      end
      want = expected_q.pop_front();
      msg  = "";
      if (got.kind !== want.kind)
        msg = {msg, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
      if (got.row !== want.row)
        msg = {msg, $sformatf(" row %0d/%0d", got.row, want.row)};
      if (got.start_column !== want.start_column)
        msg = {msg, $sformatf(" col %0d/%0d", got.start_column, want.start_column)};
      if (got.run_length !== want.run_length)
        msg = {msg, $sformatf(" len %0d/%0d", got.run_length, want.run_length)};
      if (got.pixel_value !== want.pixel_value)
        msg = {msg, $sformatf(" pix %h/%h", got.pixel_value, want.pixel_value)};
      if (got.is_transparent !== want.is_transparent)
        msg = {msg, $sformatf(" tr %b/%b", got.is_transparent, want.is_transparent)};
      if (got.last_result !== want.last_result)
        msg = {msg, $sformatf(" last %b/%b", got.last_result, want.last_result)};
      if (msg != "") begin
        msg = {"mismatch (got/exp):", msg};
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;

  int            err_count     = 0;
  int            send_idle_pct = 25;
  int            recv_idle_pct = 54;
  logic          hold_active   = 1'b0;
  run_scoreboard sb;
  in_item_t      stim_q[$];

  sprite_rle_line_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    err_count++;
    // keep the log bounded when the design is badly broken
    if (err_count <= MAX_PRINTS) $display("%0t: %s", $time, msg);
  endtask

  always @(negedge clk) begin
    out_stall = hold_active || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin : result_mon
    string msg;
    if (!rst && out_valid && !out_stall) begin
      if (!sb.check_result(out_item, msg)) report(msg);
    end
  end

  task automatic hold_off(input int cycles);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_active = 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_frame(input int w, input int h, input int t);
    write_reg(REG_FRAME_WIDTH, CFG_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
    write_reg(REG_TRANSPARENT_INDEX, CFG_W'(t));
    write_reg(REG_NONE, CFG_W'($urandom_range(4095)));
  endtask

  // Caller is at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    while (sb.pending() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_stim(input bit pause_midway);
    int half;
    half = stim_q.size() / 2;
    @(negedge clk);
    while (stim_q.size() > 0) begin
      if (pause_midway && stim_q.size() == half) wait_idle();
      send_item(stim_q.pop_front());
    end
  endtask

  function automatic void push_byte(logic [7:0] b, logic fin);
    in_item_t it;
    it.stream_byte = b;
    it.final_byte  = fin;
    stim_q.push_back(it);
  endfunction

  function automatic logic [7:0] rand_count(bit run_mode);
    int         sel;
    logic [7:0] c;
    sel = $urandom_range(99);
    if (sel < 8) c = 8'd0;
    else if (sel < 75) c = 8'($urandom_range(1, 12));
    else c = 8'($urandom_range(13, 255));
    // in run mode this value would end the line instead
    if (run_mode && c == CMD_END_LINE) c = 8'd254;
    return c;
  endfunction

  function automatic logic [7:0] rand_pixel();
    logic [7:0] p;
    if ($urandom_range(99) < 15) p = PIX_TRANSPARENT;
    else p = 8'($urandom_range(255));
    return p;
  endfunction

  function automatic void gen_line();
    int         sel;
    int         n;
    logic [7:0] b;
    sel = $urandom_range(99);
    if (sel < 15) begin
      push_byte(CMD_END_LINE, 1'b0);
    end else if (sel < 55) begin
      push_byte(CMD_RUN_LINE, 1'b0);
      n = $urandom_range(0, 4);
      repeat (n) begin
        push_byte(rand_count(1'b1), 1'b0);
        push_byte(rand_pixel(), 1'b0);
      end
      push_byte(CMD_END_LINE, 1'b0);
    end else begin
      b = 8'($urandom_range(255));
      while (b == CMD_END_SPRITE || b == CMD_END_LINE || b == CMD_RUN_LINE)
        b = 8'($urandom_range(255));
      push_byte(b, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(2) == 0) begin
          push_byte(CODE_MIXED_RUN, 1'b0);
          push_byte(rand_count(1'b0), 1'b0);
          push_byte(rand_pixel(), 1'b0);
        end else if ($urandom_range(99) < 15) begin
          push_byte(PIX_TRANSPARENT, 1'b0);
        end else begin
          push_byte(8'($urandom_range(253)), 1'b0);
        end
      end
      push_byte(CMD_END_LINE, 1'b0);
    end
  endfunction

  function automatic void gen_sprite();
    int first;
    int sel;
    int cut;
    first = stim_q.size();
    repeat ($urandom_range(1, 5)) gen_line();
    sel = $urandom_range(99);
    if (sel < 45) begin
      push_byte(CMD_END_SPRITE, 1'b1);
    end else if (sel < 60) begin
      // end of sprite, then ignored trailing bytes up to the final one
      push_byte(CMD_END_SPRITE, 1'b0);
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(255)), 1'b0);
      push_byte(8'($urandom_range(255)), 1'b1);
    end else if (sel < 70) begin
      stim_q[stim_q.size()-1].final_byte = 1'b1;
    end else if (sel < 90) begin
      cut = $urandom_range(first, stim_q.size() - 1);
      while (stim_q.size() > cut + 1) void'(stim_q.pop_back());
      stim_q[cut].final_byte = 1'b1;
    end else begin
      repeat ($urandom_range(1, 8))
        push_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
      push_byte(8'($urandom_range(255)), 1'b1);
    end
  endfunction

  function automatic void gen_directed();
    // width 10, height 3
    push_byte(CMD_RUN_LINE, 1'b0);
    push_byte(8'd3, 1'b0);      push_byte(8'h07, 1'b0);
    push_byte(8'd0, 1'b0);      push_byte(8'h09, 1'b0);            // zero count
    push_byte(8'd20, 1'b0);     push_byte(PIX_TRANSPARENT, 1'b0);  // clipped, transparent
    push_byte(8'd2, 1'b0);      push_byte(8'h01, 1'b0);            // starts at the width
    push_byte(CMD_END_LINE, 1'b0);
    push_byte(CMD_END_LINE, 1'b0);                                 // empty line
    push_byte(8'h41, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(PIX_TRANSPARENT, 1'b0);
    push_byte(CODE_MIXED_RUN, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h33, 1'b0);                                        // single pixel past width
    push_byte(CMD_END_LINE, 1'b0);
    push_byte(8'h80, 1'b0);                                        // height limit
    push_byte(8'h12, 1'b0);
    push_byte(CMD_END_SPRITE, 1'b1);                               // re-arm, silent
    push_byte(CMD_END_SPRITE, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(CMD_RUN_LINE, 1'b0);   push_byte(8'd5, 1'b1);        // truncated in a pair
    push_byte(CMD_RUN_LINE, 1'b0);   push_byte(8'd5, 1'b0);
    push_byte(PIX_TRANSPARENT, 1'b1);                              // run, then truncated
    push_byte(CMD_END_LINE, 1'b1);
    push_byte(CMD_END_SPRITE, 1'b1);
  endfunction

  initial begin : main
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset configuration: zero width and height
    repeat (3) gen_sprite();
    run_stim(1'b0);
    wait_idle();

    set_frame(10, 3, 8'h5A);
    gen_directed();
    run_stim(1'b0);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph / 3)
        0: begin send_idle_pct = 25; recv_idle_pct = 54; end
        1: begin send_idle_pct = 54; recv_idle_pct = 25; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (ph)
        0: set_frame(4095, 4095, 255);
        1: set_frame(0, 4095, 0);
        2: set_frame(1, 1, $urandom_range(255));
        3: set_frame($urandom_range(1, 40), $urandom_range(1, 6), $urandom_range(255));
        4: set_frame($urandom_range(100, 300), 4, $urandom_range(255));
        5: set_frame($urandom_range(1, 4095), $urandom_range(0, 4095), $urandom_range(255));
        6: set_frame(64, 4095, $urandom_range(255));
        7: set_frame(8, 2, $urandom_range(255));
        default: set_frame($urandom_range(1, 40), $urandom_range(0, 6), $urandom_range(255));
      endcase
      while (stim_q.size() < PHASE_ITEMS) gen_sprite();
      if (ph == 6) fork hold_off(400); join_none
      run_stim(ph == 4);
      wait_idle();
    end

    if (sb.pending() != 0) report($sformatf("%0d expected items never arrived", sb.pending()));
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
